### hdl/owse_pkg.sv
// Package with the item types, codes and CRC helper of the 1-Wire search-ROM engine.
`default_nettype none
package owse_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_BEGIN = 2'd1,
    OP_PAIR  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_PROGRESS    = 3'd0,
    ST_FOUND       = 3'd1,
    ST_NO_PRESENCE = 3'd2,
    ST_ABORTED     = 3'd3,
    ST_CHECK_FAIL  = 3'd4
  } status_t;

  localparam logic [6:0] FAMILY_LIMIT = 7'd9;
  localparam logic [7:0] END_POSITION = 8'd65;
  localparam logic [7:0] CRC_INIT     = 8'h00;
  localparam logic [7:0] CRC_POLY     = 8'h8C;

  typedef struct packed {
    logic [1:0] operation;
    logic       presence;
    logic       id_bit;
    logic       complement_bit;
  } item_t;

  typedef struct packed {
    logic        direction;
    logic [2:0]  status;
    logic [63:0] rom_id;
    logic        last_device;
    logic [3:0]  family_discrepancy;
  } result_t;

  // One bit of the reflected Dallas CRC-8.
  function automatic logic [7:0] crc8_bit(input logic [7:0] crc, input logic din);
    logic fb;
    begin
      fb = crc[0] ^ din;
      crc8_bit = {1'b0, crc[7:1]} ^ (fb ? CRC_POLY : 8'h00);
    end
  endfunction

endpackage
`default_nettype wire

### hdl/owse_in_if.sv
// Input channel interface: valid/ready handshake with the search item payload.
`default_nettype none
interface owse_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic       presence;
  logic       id_bit;
  logic       complement_bit;

  modport source (output valid, output operation, output presence, output id_bit,
                  output complement_bit, input ready);
  modport sink (input valid, input operation, input presence, input id_bit,
                input complement_bit, output ready);
endinterface
`default_nettype wire

### hdl/owse_out_if.sv
// Result channel interface: valid/ready handshake with the search result payload.
`default_nettype none
interface owse_out_if;
  logic        valid;
  logic        ready;
  logic        direction;
  logic [2:0]  status;
  logic [63:0] rom_id;
  logic        last_device;
  logic [3:0]  family_discrepancy;

  modport source (output valid, output direction, output status, output rom_id,
                  output last_device, output family_discrepancy, input ready);
  modport sink (input valid, input direction, input status, input rom_id,
                input last_device, input family_discrepancy, output ready);
endinterface
`default_nettype wire

### hdl/owse_core.sv
// Search state registers and the per-item decision, CRC and check logic.
`default_nettype none
module owse_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step_en,
  input  wire owse_pkg::item_t  item,
  output owse_pkg::result_t     res
);
  import owse_pkg::*;

  logic [63:0] rom_r,        rom_nxt;
  logic [6:0]  prev_disc_r,  prev_disc_nxt;
  logic [3:0]  fam_disc_r,   fam_disc_nxt;
  logic        all_found_r,  all_found_nxt;
  logic [6:0]  bit_pos_r,    bit_pos_nxt;
  logic [6:0]  zero_pos_r,   zero_pos_nxt;
  logic [7:0]  crc_r,        crc_nxt;
  logic        active_r,     active_nxt;

  logic [5:0]  idx;
  logic [7:0]  pos_inc;
  logic        dir;
  status_t     status;
  logic [63:0] dev;

  assign idx     = 6'(bit_pos_r - 7'd1);
  assign pos_inc = {1'b0, bit_pos_r} + 8'd1;

  always_comb begin
    rom_nxt       = rom_r;
    prev_disc_nxt = prev_disc_r;
    fam_disc_nxt  = fam_disc_r;
    all_found_nxt = all_found_r;
    bit_pos_nxt   = bit_pos_r;
    zero_pos_nxt  = zero_pos_r;
    crc_nxt       = crc_r;
    active_nxt    = active_r;
    dir           = 1'b0;
    status        = ST_PROGRESS;
    dev           = 64'd0;
    unique case (item.operation)
      OP_CLEAR: begin
        rom_nxt       = 64'd0;
        prev_disc_nxt = 7'd0;
        fam_disc_nxt  = 4'd0;
        all_found_nxt = 1'b0;
        bit_pos_nxt   = 7'd1;
        zero_pos_nxt  = 7'd0;
        crc_nxt       = CRC_INIT;
        active_nxt    = 1'b0;
      end
      OP_BEGIN: begin
        if (!item.presence) begin
          prev_disc_nxt = 7'd0;
          fam_disc_nxt  = 4'd0;
          all_found_nxt = 1'b0;
          active_nxt    = 1'b0;
          status        = ST_NO_PRESENCE;
        end else begin
          active_nxt    = 1'b1;
          bit_pos_nxt   = 7'd1;
          zero_pos_nxt  = 7'd0;
          crc_nxt       = CRC_INIT;
        end
      end
      OP_PAIR: begin
        if (active_r) begin
          if (item.id_bit && item.complement_bit) begin
            prev_disc_nxt = 7'd0;
            fam_disc_nxt  = 4'd0;
            all_found_nxt = 1'b0;
            active_nxt    = 1'b0;
            status        = ST_ABORTED;
          end else begin
            if (item.id_bit != item.complement_bit) begin
              dir = item.id_bit;
            end else begin
              // Discrepancy: follow the last pass below it, take 1 at it, 0 above.
              if (bit_pos_r < prev_disc_r) begin
                dir = rom_r[idx];
              end else begin
                dir = (bit_pos_r == prev_disc_r);
              end
              if (!dir) begin
                zero_pos_nxt = bit_pos_r;
                if (bit_pos_r < FAMILY_LIMIT) begin
                  fam_disc_nxt = bit_pos_r[3:0];
                end
              end
            end
            rom_nxt[idx] = dir;
            crc_nxt      = crc8_bit(crc_r, dir);
            bit_pos_nxt  = pos_inc[6:0];
            if (pos_inc >= END_POSITION) begin
              active_nxt  = 1'b0;
              bit_pos_nxt = 7'd1;
              if (crc_nxt == 8'd0 && rom_nxt[7:0] != 8'd0) begin
                prev_disc_nxt = zero_pos_nxt;
                if (zero_pos_nxt == 7'd0) begin
                  all_found_nxt = 1'b1;
                end
                status = ST_FOUND;
                dev    = rom_nxt;
              end else begin
                prev_disc_nxt = 7'd0;
                fam_disc_nxt  = 4'd0;
                all_found_nxt = 1'b0;
                status        = ST_CHECK_FAIL;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.direction          = dir;
    res.status             = status;
    res.rom_id             = dev;
    res.last_device        = all_found_nxt;
    res.family_discrepancy = fam_disc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_r       <= 64'd0;
      prev_disc_r <= 7'd0;
      fam_disc_r  <= 4'd0;
      all_found_r <= 1'b0;
      bit_pos_r   <= 7'd1;
      zero_pos_r  <= 7'd0;
      crc_r       <= CRC_INIT;
      active_r    <= 1'b0;
    end else if (step_en) begin
      rom_r       <= rom_nxt;
      prev_disc_r <= prev_disc_nxt;
      fam_disc_r  <= fam_disc_nxt;
      all_found_r <= all_found_nxt;
      bit_pos_r   <= bit_pos_nxt;
      zero_pos_r  <= zero_pos_nxt;
      crc_r       <= crc_nxt;
      active_r    <= active_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/onewire_rom_search_engine.sv
// An accepted item is held in the input register and its result is registered in
// the output register once that is free. Throughput: one item per cycle unless
// the output stalls; both registers let a new item in while a finished result waits.
// The decision step is a single short combinational pass in the core.
// Reset: synchronous, active low; clears the search history and the valid flags of both registers.
`default_nettype none
module onewire_rom_search_engine (
  input  wire logic  clk,
  input  wire logic  rst_n,
  owse_in_if.sink    in_if,
  owse_out_if.source out_if
);
  import owse_pkg::*;

  item_t   in_item_r;
  logic    in_valid_r, in_valid_nxt;
  result_t out_res_r;
  logic    out_valid_r, out_valid_nxt;
  result_t core_res;
  logic    advance;
  logic    in_take;

  assign advance     = in_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !in_valid_r || advance;
  assign in_take     = in_if.valid && in_if.ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.operation      <= in_if.operation;
      in_item_r.presence       <= in_if.presence;
      in_item_r.id_bit         <= in_if.id_bit;
      in_item_r.complement_bit <= in_if.complement_bit;
    end
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  owse_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_item_r),
    .res     (core_res)
  );

  assign out_if.valid              = out_valid_r;
  assign out_if.direction          = out_res_r.direction;
  assign out_if.status             = out_res_r.status;
  assign out_if.rom_id             = out_res_r.rom_id;
  assign out_if.last_device        = out_res_r.last_device;
  assign out_if.family_discrepancy = out_res_r.family_discrepancy;

endmodule
`default_nettype wire
